@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// SLG_ASSERT: clocked check, disabled while reset is high.
// SLG_ASSERT_NR: clocked check that also runs during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SLG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define SLG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define SLG_ASSERT(lbl, clk, rst, prop)
`define SLG_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ rtl/slg_pkg.sv @@
package slg_pkg;

  localparam int LAG_LONG          = 55;
  localparam int LAG_SHORT         = 24;
  localparam int LAG_DIFF          = LAG_LONG - LAG_SHORT;
  localparam int SEED_STRIDE       = 21;
  localparam int SEED_MOD          = LAG_LONG - 1;
  localparam int IDX_W             = $clog2(LAG_LONG);
  localparam int IDX_LAST          = LAG_LONG - 1;
  localparam int Q32_W             = 32;
  localparam int FRACTION_BITS_DEF = 32;

  localparam logic [Q32_W-1:0] SEED_RESET = 32'h8000_0000;

  // 1e-9 as a fraction, rounded
  localparam logic [63:0] STEP_DIV  = 64'd1000000000;
  localparam logic [63:0] STEP_HALF = 64'd500000000;

  typedef enum logic [1:0] {
    OP_RESEED   = 2'd0,
    OP_FRACTION = 2'd1,
    OP_INT      = 2'd2,
    OP_REAL     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEED_TOP,
    ST_SEED,
    ST_RF_RD,
    ST_RF_WR,
    ST_FETCH_RD,
    ST_FETCH_WAIT,
    ST_RANGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } tbl_ctrl_t;

  // packed so that fraction lands in the low bits of the output word
  typedef struct packed {
    logic [Q32_W-1:0] real_result;
    logic [Q32_W-1:0] int_result;
    logic [Q32_W-1:0] fraction;
  } res_t;

endpackage

@@ rtl/subtractive_lagged_random_generator.sv @@
// channel  | dir | handshake                    | word
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: range_low, range_high
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: fraction, int_result, real_result
// cfg      | in  | cfg_valid/cfg_ready          | cfg_data: seed
//
// Fraction fetch: table read only; ranged fetch: also passes the 4-stage multiply/map unit.
// Every 54th fetch adds a refill: each table entry takes a read state and a write state
// through the registered read of the 55-entry table and the single subtractor.
// Reseed: 55 seed writes plus three refills.
// rst is synchronous; the table reads as zero after reset until the first reseed.
// Input is taken only in idle; a result waits in the output register while the next
// word is accepted.
module subtractive_lagged_random_generator
  import slg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] range_low, [63:32] range_high
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] fraction, [63:32] int_result, [95:64] real_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [Q32_W-1:0]         seed;
  tbl_ctrl_t                tbl;
  logic [FRACTION_BITS-1:0] tbl_wdata;
  logic [FRACTION_BITS-1:0] rd_a;
  logic [FRACTION_BITS-1:0] rd_b;
  logic                     rng_start;
  logic                     rng_is_int;
  logic [Q32_W-1:0]         rng_frac;
  logic signed [Q32_W-1:0]  rng_low;
  logic signed [Q32_W-1:0]  rng_high;
  logic                     rng_done;
  logic signed [Q32_W-1:0]  rng_value;
  logic                     res_valid;
  res_t                     res;
  logic                     out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed <= cfg_data;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_axis_tdata <= res;
    end
  end

  slg_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (op_t'(s_axis_tuser)),
    .in_low     ($signed(s_axis_tdata[31:0])),
    .in_high    ($signed(s_axis_tdata[63:32])),
    .seed       (seed),
    .tbl        (tbl),
    .tbl_wdata  (tbl_wdata),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .rng_start  (rng_start),
    .rng_is_int (rng_is_int),
    .rng_frac   (rng_frac),
    .rng_low    (rng_low),
    .rng_high   (rng_high),
    .rng_done   (rng_done),
    .rng_value  (rng_value),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free)
  );

  slg_table #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl),
    .wdata   (tbl_wdata),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  slg_range u_range (
    .clk    (clk),
    .rst    (rst),
    .start  (rng_start),
    .is_int (rng_is_int),
    .frac   (rng_frac),
    .low    (rng_low),
    .high   (rng_high),
    .done   (rng_done),
    .value  (rng_value)
  );

endmodule

@@ rtl/slg_table.sv @@
module slg_table
  import slg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbl_ctrl_t                ctl,
  input  logic [FRACTION_BITS-1:0] wdata,
  output logic [FRACTION_BITS-1:0] rdata_a,
  output logic [FRACTION_BITS-1:0] rdata_b
);

  logic [FRACTION_BITS-1:0] mem [LAG_LONG];
  logic [LAG_LONG-1:0]      vld;
  logic [LAG_LONG-1:0]      vld_next;
  logic [FRACTION_BITS-1:0] ra;
  logic [FRACTION_BITS-1:0] rb;
  logic                     va;
  logic                     vb;

  // entries never written since reset or reseed read as zero
  always_comb begin
    vld_next = ctl.clr ? '0 : vld;
    if (ctl.we) begin
      vld_next[ctl.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    ra <= mem[ctl.raddr_a];
    rb <= mem[ctl.raddr_b];
    va <= vld[ctl.raddr_a];
    vb <= vld[ctl.raddr_b];
  end

  assign rdata_a = va ? ra : '0;
  assign rdata_b = vb ? rb : '0;

endmodule

@@ rtl/slg_range.sv @@
module slg_range
  import slg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    is_int,
  input  logic [Q32_W-1:0]        frac,
  input  logic signed [Q32_W-1:0] low,
  input  logic signed [Q32_W-1:0] high,
  output logic                    done,
  output logic signed [Q32_W-1:0] value
);

  logic [3:0] vpipe;

  // stage 1: span magnitude
  logic signed [Q32_W:0]   diff;
  logic [Q32_W:0]          diff_neg;
  logic [Q32_W-1:0]        s1_mag;
  logic [Q32_W-1:0]        s1_frac;
  logic                    s1_neg;
  logic                    s1_int;
  logic signed [Q32_W-1:0] s1_low;
  logic signed [Q32_W-1:0] s1_high;

  // stage 2: product
  logic [2*Q32_W-1:0]      s2_prod;
  logic [Q32_W-1:0]        s2_frac;
  logic                    s2_neg;
  logic                    s2_int;
  logic signed [Q32_W-1:0] s2_low;
  logic signed [Q32_W-1:0] s2_high;

  // stage 3: offset from low
  logic [2*Q32_W-1:0]      int_sum;
  logic [Q32_W:0]          off;
  logic [Q32_W:0]          s3_off;
  logic                    s3_neg;
  logic                    s3_int;
  logic signed [Q32_W-1:0] s3_low;
  logic signed [Q32_W-1:0] s3_high;

  // stage 4: final add and clamp
  logic signed [Q32_W+1:0] ext_off;
  logic signed [Q32_W+1:0] sum;

  assign diff     = (Q32_W+1)'(high) - (Q32_W+1)'(low);
  assign diff_neg = -diff;

  // integer span is diff + 1, so f * span = f * diff + f
  assign int_sum = s2_prod + (2*Q32_W)'(s2_frac);

  always_comb begin
    if (s2_int) begin
      off = {1'b0, int_sum[2*Q32_W-1:Q32_W]};
    end else begin
      // negative span rounds the magnitude up so the result floors
      off = (Q32_W+1)'(s2_prod[2*Q32_W-1:Q32_W])
          + (Q32_W+1)'(s2_neg && (s2_prod[Q32_W-1:0] != '0));
    end
  end

  assign ext_off = $signed({1'b0, s3_off});
  assign sum     = s3_neg ? ((Q32_W+2)'(s3_low) - ext_off)
                          : ((Q32_W+2)'(s3_low) + ext_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_neg  <= diff[Q32_W];
      s1_mag  <= diff[Q32_W] ? diff_neg[Q32_W-1:0] : diff[Q32_W-1:0];
      s1_frac <= frac;
      s1_int  <= is_int;
      s1_low  <= low;
      s1_high <= high;
    end
    if (vpipe[0]) begin
      s2_prod <= s1_mag * s1_frac;
      s2_frac <= s1_frac;
      s2_neg  <= s1_neg;
      s2_int  <= s1_int;
      s2_low  <= s1_low;
      s2_high <= s1_high;
    end
    if (vpipe[1]) begin
      s3_off  <= off;
      s3_neg  <= s2_neg;
      s3_int  <= s2_int;
      s3_low  <= s2_low;
      s3_high <= s2_high;
    end
    if (vpipe[2]) begin
      if (s3_int && (sum > (Q32_W+2)'(s3_high))) begin
        value <= s3_high;
      end else begin
        value <= sum[Q32_W-1:0];
      end
    end
  end

  assign done = vpipe[3];

endmodule

@@ rtl/slg_ctrl.sv @@
`include "assert_macros.svh"

module slg_ctrl
  import slg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  op_t                      in_op,
  input  logic signed [Q32_W-1:0]  in_low,
  input  logic signed [Q32_W-1:0]  in_high,
  input  logic [Q32_W-1:0]         seed,
  output tbl_ctrl_t                tbl,
  output logic [FRACTION_BITS-1:0] tbl_wdata,
  input  logic [FRACTION_BITS-1:0] rd_a,
  input  logic [FRACTION_BITS-1:0] rd_b,
  output logic                     rng_start,
  output logic                     rng_is_int,
  output logic [Q32_W-1:0]         rng_frac,
  output logic signed [Q32_W-1:0]  rng_low,
  output logic signed [Q32_W-1:0]  rng_high,
  input  logic                     rng_done,
  input  logic signed [Q32_W-1:0]  rng_value,
  output logic                     res_valid,
  output res_t                     res,
  input  logic                     out_free
);

  localparam int          SHIFT     = 64 - FRACTION_BITS;
  localparam logic [63:0] STEP_WIDE = ((64'd1 << FRACTION_BITS) + STEP_HALF) / STEP_DIV;
  localparam logic [FRACTION_BITS-1:0] STEP_INIT = STEP_WIDE[FRACTION_BITS-1:0];

  state_t                   state;
  state_t                   state_next;
  op_t                      op;
  logic                     degen;
  logic signed [Q32_W-1:0]  low;
  logic signed [Q32_W-1:0]  high;
  logic [IDX_W-1:0]         read_index;
  logic [IDX_W-1:0]         j;
  logic [IDX_W-1:0]         pos;
  logic [1:0]               rf_left;
  logic [FRACTION_BITS-1:0] step;
  logic [FRACTION_BITS-1:0] prev;
  logic [Q32_W-1:0]         frac;

  logic [FRACTION_BITS-1:0] sub_a;
  logic [FRACTION_BITS-1:0] sub_b;
  logic [FRACTION_BITS-1:0] sub_y;
  logic [IDX_W:0]           pos_sum;
  logic [IDX_W-1:0]         pos_next;
  logic [FRACTION_BITS-1:0] seed_scaled;
  logic [63:0]              seed_wide;
  logic [63:0]              rd_wide;
  logic [Q32_W-1:0]         rd_q32;
  logic                     j_last;

  // 0.32 <-> table fraction width
  assign seed_wide   = {seed, 32'h0} >> SHIFT;
  assign seed_scaled = seed_wide[FRACTION_BITS-1:0];
  assign rd_wide     = 64'(rd_a) << SHIFT;
  assign rd_q32      = rd_wide[63:32];

  // the one subtractor: refill entries, or the seeding recurrence
  always_comb begin
    if (state == ST_SEED) begin
      sub_a = prev;
      sub_b = step;
    end else begin
      sub_a = rd_a;
      sub_b = rd_b;
    end
  end
  assign sub_y = sub_a - sub_b;

  assign pos_sum  = (IDX_W+1)'(pos) + (IDX_W+1)'(SEED_STRIDE);
  assign pos_next = (pos_sum >= (IDX_W+1)'(SEED_MOD)) ?
                    IDX_W'(pos_sum - (IDX_W+1)'(SEED_MOD)) : pos_sum[IDX_W-1:0];
  assign j_last   = (j == IDX_W'(IDX_LAST));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (op == OP_RESEED) begin
          state_next = ST_SEED_TOP;
        end else if (degen) begin
          state_next = ST_DONE;
        end else if (read_index == IDX_W'(IDX_LAST)) begin
          state_next = ST_RF_RD;
        end else begin
          state_next = ST_FETCH_RD;
        end
      end
      ST_SEED_TOP: state_next = ST_SEED;
      ST_SEED: begin
        if (j == IDX_W'(SEED_MOD)) state_next = ST_RF_RD;
      end
      ST_RF_RD: state_next = ST_RF_WR;
      ST_RF_WR: begin
        if (!j_last) begin
          state_next = ST_RF_RD;
        end else if (rf_left != '0) begin
          state_next = ST_RF_RD;
        end else if (op == OP_RESEED) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH_RD;
        end
      end
      ST_FETCH_RD: state_next = ST_FETCH_WAIT;
      ST_FETCH_WAIT: begin
        state_next = (op == OP_FRACTION) ? ST_DONE : ST_RANGE;
      end
      ST_RANGE: begin
        if (rng_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tbl       = '0;
    tbl_wdata = sub_y;
    in_ready  = 1'b0;
    rng_start = 1'b0;
    res_valid = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SEED_TOP: begin
        tbl.clr   = 1'b1;
        tbl.we    = 1'b1;
        tbl.waddr = IDX_W'(IDX_LAST);
        tbl_wdata = seed_scaled;
      end
      ST_SEED: begin
        tbl.we    = 1'b1;
        tbl.waddr = pos;
        tbl_wdata = step;
      end
      ST_RF_RD: begin
        tbl.raddr_a = j;
        tbl.raddr_b = (j < IDX_W'(LAG_SHORT)) ? (j + IDX_W'(LAG_DIFF))
                                             : (j - IDX_W'(LAG_SHORT));
      end
      ST_RF_WR: begin
        tbl.we    = 1'b1;
        tbl.waddr = j;
      end
      ST_FETCH_RD:   tbl.raddr_a = read_index;
      ST_FETCH_WAIT: rng_start = (op != OP_FRACTION);
      ST_DONE:       res_valid = 1'b1;
      default: ;
    endcase
  end

  assign rng_is_int = (op == OP_INT);
  assign rng_frac   = rd_q32;
  assign rng_low    = low;
  assign rng_high   = high;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      read_index <= '0;
      j          <= '0;
      rf_left    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_DECODE: begin
          if (op != OP_RESEED && !degen) begin
            if (read_index == IDX_W'(IDX_LAST)) begin
              read_index <= IDX_W'(1);
              j          <= '0;
              rf_left    <= '0;
            end else begin
              read_index <= read_index + 1'b1;
            end
          end
        end
        ST_SEED_TOP: begin
          j          <= IDX_W'(1);
          read_index <= '0;
        end
        ST_SEED: begin
          if (j == IDX_W'(SEED_MOD)) begin
            j       <= '0;
            rf_left <= 2'd2;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_RF_WR: begin
          if (j_last) begin
            j <= '0;
            if (rf_left != '0) rf_left <= rf_left - 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op    <= in_op;
          low   <= in_low;
          high  <= in_high;
          frac  <= '0;
          degen <= (in_op == OP_INT) && (in_low >= in_high);
        end
      end
      ST_SEED_TOP: begin
        step <= STEP_INIT;
        prev <= seed_scaled;
        pos  <= IDX_W'(SEED_STRIDE);
      end
      ST_SEED: begin
        step <= sub_y;
        prev <= step;
        pos  <= pos_next;
      end
      ST_FETCH_WAIT: frac <= rd_q32;
      default: ;
    endcase
  end

  always_comb begin
    res.fraction    = frac;
    res.int_result  = '0;
    res.real_result = '0;
    if (degen) begin
      res.int_result = low;
    end else if (op == OP_INT) begin
      res.int_result = rng_value;
    end else if (op == OP_REAL) begin
      res.real_result = rng_value;
    end
  end

  `SLG_ASSERT(a_index_bound, clk, rst, read_index <= IDX_W'(IDX_LAST))
  `SLG_ASSERT(a_range_done_wait, clk, rst, rng_done |-> state == ST_RANGE)
  `SLG_ASSERT(a_reseed_index, clk, rst, (state == ST_DONE && op == OP_RESEED) |-> read_index == '0)
  `SLG_ASSERT_NR(a_reset_idle, clk, rst |=> (state == ST_IDLE && read_index == '0))

endmodule
